// File: src/tob_pkg.sv
// ----------------------------------------------------------------------------
// tob_pkg
// Shared types and constants for the tile overlap blend unit.
// ----------------------------------------------------------------------------
package tob_pkg;

    localparam int MAX_TILES  = 16;
    localparam int TILE_IDX_W = $clog2(MAX_TILES);
    localparam int COUNT_W    = 5;
    localparam int CFG_W      = 5;
    localparam int RAMP_W     = 17;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [3:0]  tile_slot;
        logic [15:0] tile_w;
        logic [15:0] tile_h;
        logic [23:0] sample_a;
        logic [23:0] sample_b;
        logic [23:0] sample_c;
        logic [23:0] sample_d;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_ch0;
        logic [7:0]         out_ch1;
        logic [7:0]         out_ch2;
        logic [COUNT_W-1:0] cover_count;
    } out_item_t;

    typedef struct packed {
        logic [23:0]        s_a;
        logic [23:0]        s_b;
        logic [23:0]        s_c;
        logic [23:0]        s_d;
        logic [RAMP_W-1:0]  nx;
        logic [RAMP_W-1:0]  dx;
        logic [RAMP_W-1:0]  ny;
        logic [RAMP_W-1:0]  dy;
        logic [COUNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic [RAMP_W-1:0] n;
        logic [RAMP_W-1:0] d;
    } ramp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

// File: src/tob_front.sv
// ----------------------------------------------------------------------------
// tob_front
// Holds the tile table, takes transactions, finds covering tiles and ramps.
// ----------------------------------------------------------------------------
module tob_front
    import tob_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    input  logic [CFG_W-1:0]   tiles_in_use,
    input  logic               q_full,
    output logic               push,
    output job_t               job
);

    logic [15:0] ox_reg [MAX_TILES];
    logic [15:0] oy_reg [MAX_TILES];
    logic [15:0] w_reg  [MAX_TILES];
    logic [15:0] h_reg  [MAX_TILES];

    logic                 a_valid_reg, a_valid_next;
    in_item_t             a_item_reg;
    logic [MAX_TILES-1:0] a_mask_reg;
    logic [MAX_TILES-1:0] mask_now;
    logic                 accept;
    logic [CFG_W:0]       limit;

    logic [COUNT_W-1:0]    count;
    logic [TILE_IDX_W-1:0] i0, i1, i3, iy;
    ramp_t                 rx, ry;

    function automatic ramp_t ramp_f(logic [15:0] o1, logic [15:0] len,
                                     logic [15:0] o2, logic [15:0] pos);
        ramp_t       r;
        logic [16:0] e;
        logic [16:0] o2p;
        e   = {1'b0, o1} + {1'b0, len};
        o2p = {1'b0, o2} + 17'd1;
        if (e <= o2p || pos < o2)
        begin
            r.n = '0;
            r.d = RAMP_W'(1);
        end
        else
        begin
            r.d = e - o2p;
            r.n = {1'b0, pos} - {1'b0, o2};
            if (r.n > r.d)
                r.n = r.d;
        end
        return r;
    endfunction

    assign in_stall = a_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = a_valid_reg && !q_full;
    assign limit    = ({1'b0, tiles_in_use} > (CFG_W+1)'(MAX_TILES)) ?
                      (CFG_W+1)'(MAX_TILES) : {1'b0, tiles_in_use};

    always_comb
    begin
        for (int i = 0; i < MAX_TILES; i++)
        begin
            mask_now[i] = ((CFG_W+1)'(i) < limit) &&
                (in_data.pos_x >= ox_reg[i]) &&
                ({1'b0, in_data.pos_x} < {1'b0, ox_reg[i]} + {1'b0, w_reg[i]}) &&
                (in_data.pos_y >= oy_reg[i]) &&
                ({1'b0, in_data.pos_y} < {1'b0, oy_reg[i]} + {1'b0, h_reg[i]});
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (push)
            a_valid_next = 1'b0;
        if (accept && in_data.op == OP_BLEND)
            a_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TILES; i++)
            begin
                ox_reg[i] <= '0;
                oy_reg[i] <= '0;
                w_reg[i]  <= '0;
                h_reg[i]  <= '0;
            end
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (accept && in_data.op == OP_LOAD)
            begin
                ox_reg[in_data.tile_slot[TILE_IDX_W-1:0]] <= in_data.pos_x;
                oy_reg[in_data.tile_slot[TILE_IDX_W-1:0]] <= in_data.pos_y;
                w_reg[in_data.tile_slot[TILE_IDX_W-1:0]]  <= in_data.tile_w;
                h_reg[in_data.tile_slot[TILE_IDX_W-1:0]]  <= in_data.tile_h;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.op == OP_BLEND)
        begin
            a_item_reg <= in_data;
            a_mask_reg <= mask_now;
        end
    end

    // index of the first, second and fourth covering tile
    always_comb
    begin
        logic [MAX_TILES-1:0] below;
        logic [COUNT_W-1:0]   rank;
        i0 = '0;
        i1 = '0;
        i3 = '0;
        for (int i = 0; i < MAX_TILES; i++)
        begin
            below = a_mask_reg & ((MAX_TILES'(1) << i) - MAX_TILES'(1));
            rank  = COUNT_W'($countones(below));
            if (a_mask_reg[i] && rank == COUNT_W'(0))
                i0 = TILE_IDX_W'(i);
            if (a_mask_reg[i] && rank == COUNT_W'(1))
                i1 = TILE_IDX_W'(i);
            if (a_mask_reg[i] && rank == COUNT_W'(3))
                i3 = TILE_IDX_W'(i);
        end
    end

    assign count = COUNT_W'($countones(a_mask_reg));
    assign iy    = (count == COUNT_W'(4)) ? i3 : i1;
    assign rx    = ramp_f(ox_reg[i0], w_reg[i0], ox_reg[i1], a_item_reg.pos_x);
    assign ry    = ramp_f(oy_reg[i0], h_reg[i0], oy_reg[iy], a_item_reg.pos_y);

    always_comb
    begin
        job       = '0;
        job.count = count;
        job.dx    = RAMP_W'(1);
        job.dy    = RAMP_W'(1);
        case (count)
            COUNT_W'(1):
            begin
                job.s_a = a_item_reg.sample_a;
            end
            COUNT_W'(2):
            begin
                job.s_a = a_item_reg.sample_a;
                job.s_b = a_item_reg.sample_b;
                if ({1'b0, i0} + 1'b1 == {1'b0, i1})
                begin
                    job.nx = rx.n;
                    job.dx = rx.d;
                end
                else
                begin
                    job.nx = ry.n;
                    job.dx = ry.d;
                end
            end
            COUNT_W'(4):
            begin
                job.s_a = a_item_reg.sample_a;
                job.s_b = a_item_reg.sample_b;
                job.s_c = a_item_reg.sample_c;
                job.s_d = a_item_reg.sample_d;
                job.nx  = rx.n;
                job.dx  = rx.d;
                job.ny  = ry.n;
                job.dy  = ry.d;
            end
            default:
            begin
                job.s_a = '0;
            end
        endcase
    end

endmodule

// File: src/tob_queue.sv
// ----------------------------------------------------------------------------
// tob_queue
// Two-entry job queue between classification and arithmetic.
// ----------------------------------------------------------------------------
module tob_queue
    import tob_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_job = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

// File: src/tob_back.sv
// ----------------------------------------------------------------------------
// tob_back
// Weighted sums and rounded division for three channels, output register.
// ----------------------------------------------------------------------------
module tob_back
    import tob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    back_state_t state_reg, state_next;

    job_t               job_reg;
    logic [24:0]        top_reg [3];
    logic [24:0]        bot_reg [3];
    logic [41:0]        tot_reg [3];
    logic [33:0]        den_reg;
    logic [43:0]        rem_reg [3];
    logic [43:0]        dsh_reg;
    logic [7:0]         quo_reg [3];
    logic [2:0]         bit_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    logic               load_out;
    logic               out_free;

    logic [RAMP_W-1:0] wx0, wy0;
    logic [7:0]        ca [3];
    logic [7:0]        cb [3];
    logic [7:0]        cc [3];
    logic [7:0]        cd [3];

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign wx0       = job_reg.dx - job_reg.nx;
    assign wy0       = job_reg.dy - job_reg.ny;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ca[k] = job_reg.s_a[8*k +: 8];
            cb[k] = job_reg.s_b[8*k +: 8];
            cc[k] = job_reg.s_c[8*k +: 8];
            cd[k] = job_reg.s_d[8*k +: 8];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_MUL1;
            B_MUL1: state_next = B_MUL2;
            B_MUL2: state_next = B_PREP;
            B_PREP: state_next = B_DIV;
            B_DIV:  if (bit_reg == 3'd0) state_next = B_DONE;
            B_DONE: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE: pop = !q_empty;
            B_DONE: load_out = out_free;
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        case (state_reg)
            B_MUL1:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    top_reg[k] <= 25'(ca[k]) * 25'(wx0) + 25'(cb[k]) * 25'(job_reg.nx);
                    bot_reg[k] <= 25'(cc[k]) * 25'(wx0) + 25'(cd[k]) * 25'(job_reg.nx);
                end
            end
            B_MUL2:
            begin
                for (int k = 0; k < 3; k++)
                    tot_reg[k] <= 42'(top_reg[k]) * 42'(wy0) +
                                  42'(bot_reg[k]) * 42'(job_reg.ny);
                den_reg <= 34'(job_reg.dx) * 34'(job_reg.dy);
            end
            B_PREP:
            begin
                for (int k = 0; k < 3; k++)
                    rem_reg[k] <= {1'b0, tot_reg[k], 1'b0} + 44'(den_reg);
                dsh_reg <= {2'b0, den_reg, 8'd0};
                bit_reg <= 3'd7;
            end
            B_DIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (rem_reg[k] >= dsh_reg)
                    begin
                        rem_reg[k] <= rem_reg[k] - dsh_reg;
                        quo_reg[k] <= {quo_reg[k][6:0], 1'b1};
                    end
                    else
                        quo_reg[k] <= {quo_reg[k][6:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                bit_reg <= bit_reg - 3'd1;
            end
            default:
            begin
                bit_reg <= bit_reg;
            end
        endcase
        if (load_out)
        begin
            out_reg.out_ch0     <= quo_reg[0];
            out_reg.out_ch1     <= quo_reg[1];
            out_reg.out_ch2     <= quo_reg[2];
            out_reg.cover_count <= job_reg.count;
        end
    end

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV && bit_reg == 3'd0) |=> state_reg == B_DONE)
        else $error("divider did not finish after last step");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == B_MUL1)
        else $error("job popped without starting");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == B_IDLE)
        else $error("result load not visible");

endmodule

// File: src/tile_overlap_blend_unit.sv
// ----------------------------------------------------------------------------
// tile_overlap_blend_unit
// Feathered blending of overlapping tiles: tile table, coverage, weighting.
// ----------------------------------------------------------------------------
// Load transactions write the tile table when accepted; they wait only while a pixel is held
// in front and the job queue is full.
// A pixel passes the front register, the job queue, back states MUL1 to DONE and the
// output register. The back sequencer takes one pixel at a time through the eight-step
// restoring divider in each of the three channel lanes, while the front and queue can take new pixels.
// Reset clears the tile table to zero and sets tiles_in_use to 1.
module tile_overlap_blend_unit
    import tob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] tiles_reg;
    logic             push, pop, q_full, q_empty;
    job_t             push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tiles_reg <= CFG_W'(1);
        else if (cfg_valid && cfg_ready)
            tiles_reg <= cfg_data;
    end

    tob_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .tiles_in_use (tiles_reg),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    tob_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    tob_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
